// ----- hdl/ptd_pkg.sv -----
// shared types and constants for the prime table trial divider
// used by ptd_delta_ram, ptd_div_serial and prime_table_trial_divider_unit
package ptd_pkg;

    localparam int DEF_MAX_DELTAS = 128;
    localparam int DIV_W          = 32;
    localparam int PRIME_W        = 16;
    localparam int DELTA_W        = 8;
    localparam int COUNT_OUT_W    = 8;
    localparam int DELTA_LIMIT    = 254;
    localparam int BASE_PRIME     = 2;
    localparam int RESET_LAST     = 5;
    localparam int RESET_COUNT    = 2;
    localparam int FIRST_DELTA    = 1;
    localparam int SECOND_DELTA   = 2;

    typedef enum logic [1:0] {
        K_FACTOR  = 2'd0,
        K_EXTEND  = 2'd1,
        K_RESTART = 2'd2,
        K_UNUSED  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_FOUND    = 3'd0,
        ST_NONE     = 3'd1,
        ST_APPENDED = 3'd2,
        ST_FULL     = 3'd3,
        ST_RESTART  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND,
        S_START,
        S_DIV,
        S_FINISH
    } t_ptd_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
    } t_ptd_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] divisor;
        logic [31:0] quotient;
        logic [15:0] new_prime;
        logic [7:0]  table_count;
    } t_ptd_out;

    // status of the serial divider toward the controller
    typedef struct packed {
        logic              done;
        logic              rem_zero;
        logic [DIV_W-1:0]  quotient;
    } t_div_res;

endpackage

// ----- hdl/ptd_delta_ram.sv -----
// delta table storage: one write port, one registered read port
// first two deltas are fixed; depends on ptd_pkg
module ptd_delta_ram #(
    parameter int MAX_DELTAS = ptd_pkg::DEF_MAX_DELTAS
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [$clog2(MAX_DELTAS)-1:0]        i_waddr,
    input  logic [ptd_pkg::DELTA_W-1:0]          i_wdata,
    input  logic [$clog2(MAX_DELTAS)-1:0]        i_raddr,
    output logic [ptd_pkg::DELTA_W-1:0]          o_rdata
);
    import ptd_pkg::*;

    localparam int AW = $clog2(MAX_DELTAS);

    logic [DELTA_W-1:0] r_mem [MAX_DELTAS];
    logic [DELTA_W-1:0] r_rd;
    logic               r_first;
    logic               r_second;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd     <= r_mem[i_raddr];
        r_first  <= (i_raddr == AW'(0));
        r_second <= (i_raddr == AW'(1));
    end

    // deltas 0 and 1 never get rewritten, so they come from constants
    always_comb begin
        if (r_first) begin
            o_rdata = DELTA_W'(FIRST_DELTA);
        end else if (r_second) begin
            o_rdata = DELTA_W'(SECOND_DELTA);
        end else begin
            o_rdata = r_rd;
        end
    end

endmodule

// ----- hdl/ptd_div_serial.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on ptd_pkg
module ptd_div_serial (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ptd_pkg::DIV_W-1:0]     i_dividend,
    input  logic [ptd_pkg::PRIME_W-1:0]   i_divisor,
    output ptd_pkg::t_div_res             o_res
);
    import ptd_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]   r_quo;
    logic [PRIME_W-1:0] r_rem;
    logic [PRIME_W-1:0] r_div;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [PRIME_W:0]   trial;
    logic               fits;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_busy <= (r_cnt != CNT_W'(1));
                r_cnt  <= CNT_W'(r_cnt - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the low bits suffice
            if (fits) begin
                r_rem <= PRIME_W'(trial - {1'b0, r_div});
            end else begin
                r_rem <= trial[PRIME_W-1:0];
            end
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_res.done     = r_done;
    assign o_res.rem_zero = (r_rem == '0);
    assign o_res.quotient = r_quo;

endmodule

// ----- hdl/prime_table_trial_divider_unit.sv -----
// top level of the prime table trial divider: request handshake, sequencer, result register
// depends on ptd_pkg, ptd_delta_ram and ptd_div_serial
//
// Keeps a table of primes as 8-bit deltas starting from 2; after reset or a
// restart request it holds 2, 3, 5. A factor request divides its value by the
// table primes in ascending order and returns the first one that divides it
// with the quotient, or status "none" with the quotient by the last prime. An
// extend request tests odd candidates above the last prime, each by trial
// division over the whole table, and appends the first that no table prime
// divides; a full table, a gap over 254 or a prime above 16 bits reports
// "full". One request is worked at a time. All division goes through a single
// bit-serial divider, so a factor request runs one division per table prime
// tried (at most table_count + 1 primes) and an extend request runs one for
// each table prime tried on each candidate. A restart request goes straight
// to the result without a division; a request with the unused kind is
// dropped and gives no result. A new request is taken while the last result
// still waits in the output register.
module prime_table_trial_divider_unit #(
    parameter int MAX_DELTAS = ptd_pkg::DEF_MAX_DELTAS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ptd_pkg::t_ptd_in   i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output ptd_pkg::t_ptd_out  o_out_data,
    input  logic               i_out_stall
);
    import ptd_pkg::*;

    localparam int AW    = $clog2(MAX_DELTAS);
    localparam int CW    = $clog2(MAX_DELTAS + 1);
    localparam int OFF_W = DELTA_W + 1;
    localparam int CAND_W = PRIME_W + 1;

    // control state
    t_ptd_state r_state, n_state;
    logic [CW-1:0]      r_count, n_count;     // deltas in the table
    logic [PRIME_W-1:0] r_last, n_last;       // largest table prime
    logic               r_out_valid, n_out_valid;

    // working registers
    logic               r_ext, n_ext;         // extend request in flight
    logic [DIV_W-1:0]   r_value, n_value;     // dividend: request value or candidate
    logic [PRIME_W-1:0] r_p, n_p;             // table prime being tried
    logic [CW-1:0]      r_k, n_k;             // index of next delta
    logic [OFF_W-1:0]   r_off, n_off;         // candidate minus last prime
    logic [2:0]         r_status, n_status;
    logic [PRIME_W-1:0] r_divisor, n_divisor;
    logic [DIV_W-1:0]   r_quot, n_quot;
    t_ptd_out           r_out, n_out;

    // divider and table hookup
    logic               div_start;
    t_div_res           div_res;
    logic               tbl_we;
    logic [DELTA_W-1:0] tbl_rdata;
    logic [CAND_W-1:0]  cand;

    ptd_div_serial u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_value),
        .i_divisor  (r_p),
        .o_res      (div_res)
    );

    // read address follows the delta index; data is ready long before the division ends
    ptd_delta_ram #(
        .MAX_DELTAS (MAX_DELTAS)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_off[DELTA_W-1:0]),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (tbl_rdata)
    );

    assign cand = CAND_W'(r_last) + CAND_W'(r_off);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_last      = r_last;
        n_ext       = r_ext;
        n_value     = r_value;
        n_p         = r_p;
        n_k         = r_k;
        n_off       = r_off;
        n_status    = r_status;
        n_divisor   = r_divisor;
        n_quot      = r_quot;
        n_out       = r_out;
        div_start   = 1'b0;
        tbl_we      = 1'b0;

        // result register empties when taken downstream
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.kind)
                        K_FACTOR: begin
                            n_ext   = 1'b0;
                            n_value = i_in_data.value;
                            n_p     = PRIME_W'(BASE_PRIME);
                            n_k     = '0;
                            n_state = S_START;
                        end
                        K_EXTEND: begin
                            n_ext     = 1'b1;
                            n_divisor = '0;
                            n_quot    = '0;
                            if (r_count >= CW'(MAX_DELTAS)) begin
                                n_status = ST_FULL;
                                n_state  = S_FINISH;
                            end else begin
                                n_off   = OFF_W'(2);
                                n_state = S_CAND;
                            end
                        end
                        K_RESTART: begin
                            n_count   = CW'(RESET_COUNT);
                            n_last    = PRIME_W'(RESET_LAST);
                            n_status  = ST_RESTART;
                            n_divisor = '0;
                            n_quot    = '0;
                            n_state   = S_FINISH;
                        end
                        default: begin
                            // unused kind: request dropped, no result
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CAND: begin
                // next odd candidate, unless the gap is already too wide
                if (r_off > OFF_W'(DELTA_LIMIT)) begin
                    n_status = ST_FULL;
                    n_state  = S_FINISH;
                end else begin
                    n_value = DIV_W'(cand);
                    n_p     = PRIME_W'(BASE_PRIME);
                    n_k     = '0;
                    n_state = S_START;
                end
            end
            S_START: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_res.done) begin
                    if (div_res.rem_zero) begin
                        if (!r_ext) begin
                            n_status  = ST_FOUND;
                            n_divisor = r_p;
                            n_quot    = div_res.quotient;
                            n_state   = S_FINISH;
                        end else begin
                            // candidate has a table divisor, try the next odd one
                            n_off   = OFF_W'(r_off + OFF_W'(2));
                            n_state = S_CAND;
                        end
                    end else if (r_k >= r_count) begin
                        // every table prime tried
                        if (!r_ext) begin
                            n_status  = ST_NONE;
                            n_divisor = '0;
                            n_quot    = div_res.quotient;
                            n_state   = S_FINISH;
                        end else if (r_value[PRIME_W]) begin
                            // next prime would not fit 16 bits
                            n_status = ST_FULL;
                            n_state  = S_FINISH;
                        end else begin
                            tbl_we   = 1'b1;
                            n_count  = CW'(r_count + 1'b1);
                            n_last   = r_value[PRIME_W-1:0];
                            n_status = ST_APPENDED;
                            n_state  = S_FINISH;
                        end
                    end else begin
                        n_p     = PRIME_W'(r_p + PRIME_W'(tbl_rdata));
                        n_k     = CW'(r_k + 1'b1);
                        n_state = S_START;
                    end
                end
            end
            S_FINISH: begin
                // wait for a free result register
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status      = r_status;
                    n_out.divisor     = r_divisor;
                    n_out.quotient    = r_quot;
                    n_out.new_prime   = r_last;
                    n_out.table_count = COUNT_OUT_W'(r_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CW'(RESET_COUNT);
            r_last      <= PRIME_W'(RESET_LAST);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ext     <= n_ext;
        r_value   <= n_value;
        r_p       <= n_p;
        r_k       <= n_k;
        r_off     <= n_off;
        r_status  <= n_status;
        r_divisor <= n_divisor;
        r_quot    <= n_quot;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // table never grows past its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_DELTAS))
        else $error("delta count above table depth");

    // appends only go to a free entry
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_we |-> (r_count < CW'(MAX_DELTAS)) && (r_count >= CW'(RESET_COUNT)))
        else $error("delta write outside free entries");

    // the divider finishes only while the sequencer waits for it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == S_DIV))
        else $error("divider done outside division wait");

    // a request that produces a result holds off the next one
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_data.kind != K_UNUSED)) |=> o_in_stall)
        else $error("new request taken while one is in flight");

endmodule
